FILE: rtl/y2yc_pkg.sv
`default_nettype none

package y2yc_pkg;

  // Scaling constants
  localparam int unsigned LumaGain    = 1197;
  localparam int unsigned LumaOffset  = 299;
  localparam int unsigned ChromaGain  = 4681;
  localparam int unsigned ChromaZero  = 128;
  localparam int unsigned ChromaRound = 164;
  localparam int unsigned ChromaLift  = 2340;
  // Bias that keeps the chroma numerator non-negative before the shift
  localparam int unsigned ChromaBias  =
      ChromaRound + ChromaLift * 256 - ChromaZero * ChromaGain;

  typedef logic signed [13:0] luma_t;
  typedef logic signed [12:0] chroma_t;

  // Scaled fields of one macropixel
  typedef struct packed {
    luma_t   y0;
    luma_t   y1;
    chroma_t cb;
    chroma_t cr;
    logic    last;
  } scaled_t;

  // Which pixel of the held macropixel goes out next
  typedef enum logic [1:0] {
    PH_PEND,
    PH_EVEN,
    PH_ODD
  } phase_e;

  // ((y * 1197) >> 6) - 299
  function automatic luma_t scale_luma(input logic [7:0] y);
    logic [18:0] p;
    logic [13:0] t;
    p = 19'(y) * 19'(LumaGain);
    t = {1'b0, p[18:6]} - 14'(LumaOffset);
    return luma_t'(t);
  endfunction

  // floor((c * 4681 - 128 * 4681 + 164) / 256)
  function automatic chroma_t scale_chroma(input logic [7:0] c);
    logic [20:0] p;
    logic [12:0] t;
    p = 21'(c) * 21'(ChromaGain) + 21'(ChromaBias);
    t = p[20:8] - 13'(ChromaLift);
    return chroma_t'(t);
  endfunction

  // floor((a + b) / 2)
  function automatic chroma_t floor_avg(input chroma_t a, input chroma_t b);
    logic [13:0] s;
    s = {a[12], a} + {b[12], b};
    return chroma_t'(s[13:1]);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/y2yc_if.sv
`default_nettype none

// YUY2 macropixel channel
interface y2yc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma_even;
  logic [7:0] cb_in;
  logic [7:0] luma_odd;
  logic [7:0] cr_in;
  logic       row_end;

  modport source (output valid, luma_even, cb_in, luma_odd, cr_in, row_end,
                  input ready);
  modport sink   (input valid, luma_even, cb_in, luma_odd, cr_in, row_end,
                  output ready);
endinterface

// YC48 pixel channel
interface y2yc_out_if;
  logic               valid;
  logic               ready;
  logic signed [13:0] luma_out;
  logic signed [12:0] cb_out;
  logic signed [12:0] cr_out;
  logic               row_last;

  modport source (output valid, luma_out, cb_out, cr_out, row_last,
                  input ready);
  modport sink   (input valid, luma_out, cb_out, cr_out, row_last,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/y2yc_scale.sv
`default_nettype none

module y2yc_scale
  import y2yc_pkg::*;
(
  input  logic [7:0] luma_even_i,
  input  logic [7:0] cb_i,
  input  logic [7:0] luma_odd_i,
  input  logic [7:0] cr_i,
  input  logic       row_end_i,
  output scaled_t    scaled_o
);

  // Byte-to-YC48 range scaling, one constant multiply per field
  always_comb begin
    scaled_o.y0   = scale_luma(luma_even_i);
    scaled_o.y1   = scale_luma(luma_odd_i);
    scaled_o.cb   = scale_chroma(cb_i);
    scaled_o.cr   = scale_chroma(cr_i);
    scaled_o.last = row_end_i;
  end

endmodule

`default_nettype wire

FILE: rtl/yuy2_to_yc48_chroma_upsample.sv
`default_nettype none

// Channel   Dir   Beat
// in_i      in    one YUY2 macropixel: luma_even, cb_in, luma_odd, cr_in, row_end
// out_o     out   one YC48 pixel: luma_out, cb_out, cr_out, row_last
//
// One pixel per cycle while out_o is not stalled; a macropixel emits 1 pixel
// when it opens a row and holds its odd pixel, 2 in mid-row (held + even) or for a
// one-macropixel row, 3 at a row end that flushes a held odd pixel.
// Reset drops any held odd pixel; nothing stored needs clearing.
// A stall on out_o holds the output register; in_i takes a new beat in the
// cycle the last pixel of the current macropixel moves to the output.

module yuy2_to_yc48_chroma_upsample
  import y2yc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  y2yc_in_if.sink     in_i,
  y2yc_out_if.source  out_o
);

  scaled_t scaled;

  logic    in_acc;
  logic    out_load;
  logic    item_done;
  phase_e  phase_step;

  // Odd pixel held across macropixels
  logic    pend_valid_q, pend_valid_d;
  luma_t   pend_luma_q,  pend_luma_d;
  chroma_t prev_cb_q,    prev_cb_d;
  chroma_t prev_cr_q,    prev_cr_d;

  // Macropixel being emitted
  logic    item_valid_q, item_valid_d;
  phase_e  phase_q,      phase_d;
  scaled_t item_q,       item_d;
  luma_t   snap_luma_q,  snap_luma_d;
  chroma_t snap_cb_q,    snap_cb_d;
  chroma_t snap_cr_q,    snap_cr_d;

  // Output register
  logic    out_valid_q,  out_valid_d;
  luma_t   out_luma_q,   out_luma_d;
  chroma_t out_cb_q,     out_cb_d;
  chroma_t out_cr_q,     out_cr_d;
  logic    out_last_q,   out_last_d;

  y2yc_scale u_scale (
    .luma_even_i (in_i.luma_even),
    .cb_i        (in_i.cb_in),
    .luma_odd_i  (in_i.luma_odd),
    .cr_i        (in_i.cr_in),
    .row_end_i   (in_i.row_end),
    .scaled_o    (scaled)
  );

  assign out_load  = item_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !item_valid_q || item_done;
  assign in_acc    = in_i.valid && in_i.ready;

  // Pixel select and phase sequencing
  always_comb begin
    phase_step = phase_q;
    item_done  = 1'b0;
    out_luma_d = out_luma_q;
    out_cb_d   = out_cb_q;
    out_cr_d   = out_cr_q;
    out_last_d = out_last_q;
    unique case (phase_q)
      PH_PEND: begin
        out_luma_d = snap_luma_q;
        out_cb_d   = floor_avg(snap_cb_q, item_q.cb);
        out_cr_d   = floor_avg(snap_cr_q, item_q.cr);
        out_last_d = 1'b0;
        if (out_load) phase_step = PH_EVEN;
      end
      PH_EVEN: begin
        out_luma_d = item_q.y0;
        out_cb_d   = item_q.cb;
        out_cr_d   = item_q.cr;
        out_last_d = 1'b0;
        if (out_load) begin
          if (item_q.last) phase_step = PH_ODD;
          else item_done = 1'b1;
        end
      end
      PH_ODD: begin
        out_luma_d = item_q.y1;
        out_cb_d   = item_q.cb;
        out_cr_d   = item_q.cr;
        out_last_d = 1'b1;
        if (out_load) item_done = 1'b1;
      end
      default: begin
        phase_step = PH_EVEN;
      end
    endcase

    if (!out_load) begin
      out_luma_d = out_luma_q;
      out_cb_d   = out_cb_q;
      out_cr_d   = out_cr_q;
      out_last_d = out_last_q;
    end

    out_valid_d = out_load ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);
  end

  // Item capture and held odd pixel update
  always_comb begin
    item_valid_d = item_valid_q;
    item_d       = item_q;
    snap_luma_d  = snap_luma_q;
    snap_cb_d    = snap_cb_q;
    snap_cr_d    = snap_cr_q;
    pend_valid_d = pend_valid_q;
    pend_luma_d  = pend_luma_q;
    prev_cb_d    = prev_cb_q;
    prev_cr_d    = prev_cr_q;
    phase_d      = phase_step;

    if (item_done) item_valid_d = 1'b0;

    if (in_acc) begin
      item_valid_d = 1'b1;
      item_d       = scaled;
      snap_luma_d  = pend_luma_q;
      snap_cb_d    = prev_cb_q;
      snap_cr_d    = prev_cr_q;
      phase_d      = pend_valid_q ? PH_PEND : PH_EVEN;
      pend_valid_d = !scaled.last;
      if (!scaled.last) begin
        pend_luma_d = scaled.y1;
        prev_cb_d   = scaled.cb;
        prev_cr_d   = scaled.cr;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      phase_q      <= PH_EVEN;
      pend_luma_q  <= '0;
      prev_cb_q    <= '0;
      prev_cr_q    <= '0;
    end else begin
      pend_valid_q <= pend_valid_d;
      item_valid_q <= item_valid_d;
      out_valid_q  <= out_valid_d;
      phase_q      <= phase_d;
      pend_luma_q  <= pend_luma_d;
      prev_cb_q    <= prev_cb_d;
      prev_cr_q    <= prev_cr_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    snap_luma_q <= snap_luma_d;
    snap_cb_q   <= snap_cb_d;
    snap_cr_q   <= snap_cr_d;
    out_luma_q  <= out_luma_d;
    out_cb_q    <= out_cb_d;
    out_cr_q    <= out_cr_d;
    out_last_q  <= out_last_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.luma_out = out_luma_q;
  assign out_o.cb_out   = out_cb_q;
  assign out_o.cr_out   = out_cr_q;
  assign out_o.row_last = out_last_q;

`ifndef NO_ASSERTIONS
  // Row-end odd pixel only for a macropixel that ends its row
  a_odd_needs_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid_q && phase_q == PH_ODD) |-> item_q.last)
    else $error("odd phase on a macropixel without row end");

  // A held odd pixel is flushed first by the next macropixel
  a_pend_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && pend_valid_q) |=> (phase_q == PH_PEND))
    else $error("held odd pixel not emitted first");

  // Hold state follows the row-end mark of the accepted beat
  a_pend_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (pend_valid_q == !$past(in_i.row_end)))
    else $error("held odd pixel flag out of step with row end");

  // An empty item slot always takes input
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !item_valid_q |-> in_i.ready)
    else $error("input stalled with empty item slot");
`endif

endmodule

`default_nettype wire
